>>> sv/hbd_pkg.sv
// Shared types, codes and constants of the chunked body decoder.
package hbd_pkg;

  localparam int MaxSizeLineDef = 9;
  localparam int SizeBitsDef    = 32;
  localparam int CountW         = 4;
  localparam int QueueDepth     = 2;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  typedef enum logic [1:0] {
    EvPayload = 2'd0,
    EvDone    = 2'd1,
    EvError   = 2'd2
  } event_kind_e;

  // One classified body byte, handed from the front to the back.
  typedef struct packed {
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [7:0] raw;
  } byte_class_t;

  typedef struct packed {
    logic halted;
    logic busy;
  } back_status_t;

endpackage

>>> sv/hbd_front.sv
// Front stage: takes body beats and classifies each byte into one register.
module hbd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     body_valid_i,
  output logic                     body_ready_o,
  input  logic [7:0]               body_byte_i,
  output logic                     cls_valid_o,
  input  logic                     cls_ready_i,
  output hbd_pkg::byte_class_t     cls_o
);

  function automatic hbd_pkg::byte_class_t classify(input logic [7:0] b);
    hbd_pkg::byte_class_t c;
    c         = '0;
    c.raw     = b;
    c.is_cr   = (b == hbd_pkg::ChCr);
    c.is_lf   = (b == hbd_pkg::ChLf);
    if (b >= 8'h30 && b <= 8'h39) begin
      c.is_hex  = 1'b1;
      c.hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      c.is_hex  = 1'b1;
      c.hex_val = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      c.is_hex  = 1'b1;
      c.hex_val = 4'(b - 8'h57);
    end
    return c;
  endfunction

  logic                 valid_q, valid_d;
  hbd_pkg::byte_class_t cls_q;
  logic                 take;

  assign body_ready_o = !valid_q || cls_ready_i;
  assign take         = body_valid_i && body_ready_o;
  assign cls_valid_o  = valid_q;
  assign cls_o        = cls_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cls_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q <= classify(body_byte_i);
    end
  end

endmodule

>>> sv/hbd_queue.sv
// Short queue of classified beats between the front and the back.
module hbd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 push_ready_o,
  input  hbd_pkg::byte_class_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_i,
  output hbd_pkg::byte_class_t pop_data_o
);

  localparam int PtrW = (hbd_pkg::QueueDepth > 1) ? $clog2(hbd_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(hbd_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(hbd_pkg::QueueDepth - 1);

  hbd_pkg::byte_class_t mem_q [hbd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(hbd_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/hbd_back.sv
// Back stage: chunk framing state machine and the output event register.
module hbd_back #(
  parameter int MaxSizeLine = hbd_pkg::MaxSizeLineDef,
  parameter int SizeBits    = hbd_pkg::SizeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 suppress_i,
  input  logic                 cls_valid_i,
  output logic                 cls_pop_o,
  input  hbd_pkg::byte_class_t cls_i,
  output logic                 event_valid_o,
  input  logic                 event_ready_i,
  output logic [1:0]           event_kind_o,
  output logic [7:0]           payload_byte_o,
  output hbd_pkg::back_status_t status_o
);

  localparam logic [2:0] PhSize   = 3'd0;
  localparam logic [2:0] PhSizeLf = 3'd1;
  localparam logic [2:0] PhData   = 3'd2;
  localparam logic [2:0] PhTrail1 = 3'd3;
  localparam logic [2:0] PhTrail2 = 3'd4;
  localparam logic [2:0] PhLastCr = 3'd5;
  localparam logic [2:0] PhLastLf = 3'd6;
  localparam logic [2:0] PhHalt   = 3'd7;

  localparam logic [hbd_pkg::CountW-1:0] MaxCount = hbd_pkg::CountW'(MaxSizeLine);

  logic [2:0]                  phase_q, phase_d;
  logic [SizeBits-1:0]         accum_q, accum_d;
  logic [SizeBits-1:0]         remain_q, remain_d;
  logic [hbd_pkg::CountW-1:0]  count_q, count_d;
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  kind_q, kind_d;
  logic [7:0]                  byte_q, byte_d;
  logic                        out_free;

  assign out_free       = !out_valid_q || event_ready_i;
  assign cls_pop_o      = cls_valid_i && out_free;
  assign event_valid_o  = out_valid_q;
  assign event_kind_o   = kind_q;
  assign payload_byte_o = byte_q;
  assign status_o.halted = (phase_q == PhHalt);
  assign status_o.busy   = out_valid_q || cls_valid_i;

  always_comb begin
    phase_d     = phase_q;
    accum_d     = accum_q;
    remain_d    = remain_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !event_ready_i;
    kind_d      = kind_q;
    byte_d      = byte_q;

    if (cls_pop_o) begin
      unique case (phase_q)
        PhSize: begin
          if (cls_i.is_cr) begin
            if (count_q == '0) begin
              phase_d     = PhHalt;
              out_valid_d = 1'b1;
              kind_d      = hbd_pkg::EvError;
              byte_d      = '0;
            end else begin
              phase_d = PhSizeLf;
            end
          end else if (!cls_i.is_hex || count_q >= MaxCount ||
                       accum_q[SizeBits-1 -: 4] != 4'd0) begin
            // Bad digit, too long a size line, or the size would overflow.
            phase_d     = PhHalt;
            out_valid_d = 1'b1;
            kind_d      = hbd_pkg::EvError;
            byte_d      = '0;
          end else begin
            accum_d = {accum_q[SizeBits-5:0], cls_i.hex_val};
            count_d = count_q + hbd_pkg::CountW'(1);
          end
        end
        PhSizeLf: begin
          if (!cls_i.is_lf) begin
            phase_d     = PhHalt;
            out_valid_d = 1'b1;
            kind_d      = hbd_pkg::EvError;
            byte_d      = '0;
          end else if (accum_q == '0) begin
            phase_d = PhLastCr;
          end else begin
            remain_d = accum_q;
            phase_d  = PhData;
          end
        end
        PhData: begin
          if (remain_q != '0) begin
            remain_d = remain_q - SizeBits'(1);
          end
          if (remain_q <= SizeBits'(1)) begin
            phase_d = PhTrail1;
          end
          if (!suppress_i) begin
            out_valid_d = 1'b1;
            kind_d      = hbd_pkg::EvPayload;
            byte_d      = cls_i.raw;
          end
        end
        PhTrail1: begin
          phase_d = PhTrail2;
        end
        PhTrail2: begin
          phase_d = PhSize;
          accum_d = '0;
          count_d = '0;
        end
        PhLastCr: begin
          if (!cls_i.is_cr) begin
            phase_d     = PhHalt;
            out_valid_d = 1'b1;
            kind_d      = hbd_pkg::EvError;
            byte_d      = '0;
          end else begin
            phase_d = PhLastLf;
          end
        end
        PhLastLf: begin
          out_valid_d = 1'b1;
          byte_d      = '0;
          if (!cls_i.is_lf) begin
            phase_d = PhHalt;
            kind_d  = hbd_pkg::EvError;
          end else begin
            phase_d  = PhSize;
            accum_d  = '0;
            count_d  = '0;
            remain_d = '0;
            kind_d   = hbd_pkg::EvDone;
          end
        end
        PhHalt: begin
          // Every beat after an error is swallowed until reset.
        end
        default: begin
          phase_d = PhHalt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSize;
      accum_q     <= '0;
      remain_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      accum_q     <= accum_d;
      remain_q    <= remain_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
  end

endmodule

>>> sv/http_chunked_body_decoder.sv
// A body beat passes the front register, the queue and the output event register.
// Throughput: one body beat per cycle, and the framing state machine in the back
// stage retires one classified byte per cycle, whenever the output register is free.
// Reset: rst_ni is asynchronous and active low; it returns the parser to the start
// of a size line, empties the queue and output register, and clears suppress_q.
// There is no clearing pass; the block is ready for beats as soon as reset is released.
module http_chunked_body_decoder #(
  parameter int MaxSizeLine = hbd_pkg::MaxSizeLineDef,
  parameter int SizeBits    = hbd_pkg::SizeBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       body_valid_i,
  output logic       body_ready_o,
  input  logic [7:0] body_byte_i,
  output logic       event_valid_o,
  input  logic       event_ready_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] payload_byte_o
);

  logic                  suppress_q;
  logic                  front_valid, queue_ready;
  hbd_pkg::byte_class_t  front_cls, queue_cls;
  logic                  queue_valid, queue_pop;
  hbd_pkg::back_status_t back_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      suppress_q <= 1'b0;
    end else if (cfg_we_i) begin
      suppress_q <= cfg_wdata_i;
    end
  end

  hbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .body_valid_i (body_valid_i),
    .body_ready_o (body_ready_o),
    .body_byte_i  (body_byte_i),
    .cls_valid_o  (front_valid),
    .cls_ready_i  (queue_ready),
    .cls_o        (front_cls)
  );

  hbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_valid),
    .push_ready_o (queue_ready),
    .push_data_i  (front_cls),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop),
    .pop_data_o   (queue_cls)
  );

  hbd_back #(
    .MaxSizeLine (MaxSizeLine),
    .SizeBits    (SizeBits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .suppress_i     (suppress_q),
    .cls_valid_i    (queue_valid),
    .cls_pop_o      (queue_pop),
    .cls_i          (queue_cls),
    .event_valid_o  (event_valid_o),
    .event_ready_i  (event_ready_i),
    .event_kind_o   (event_kind_o),
    .payload_byte_o (payload_byte_o),
    .status_o       (back_status)
  );

  // Once halted by a framing error, the parser stays halted until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.halted |=> back_status.halted)
    else $error("parser left the halted state without reset");

  // Completion and error events carry a zero data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_valid_o && event_kind_o != hbd_pkg::EvPayload) |-> (payload_byte_o == 8'd0))
    else $error("non-payload event with nonzero data byte");

  // Only the three defined event codes ever leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o |-> (event_kind_o == hbd_pkg::EvPayload ||
                       event_kind_o == hbd_pkg::EvDone ||
                       event_kind_o == hbd_pkg::EvError))
    else $error("undefined event kind on the output");

  // The back stage pops a beat only when one is queued and the output slot frees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_pop |-> (queue_valid && (!event_valid_o || event_ready_i)))
    else $error("queue popped without room in the output register");

endmodule

>>> tb/sv/hbd_event_checker.sv
// Checker that mirrors the chunked body decoder and scores every event beat it sends.
module hbd_event_checker #(
  parameter int MaxSizeLine = hbd_pkg::MaxSizeLineDef,
  parameter int SizeBits    = hbd_pkg::SizeBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       body_valid_i,
  input  logic       body_ready_i,
  input  logic [7:0] body_byte_i,
  input  logic       event_valid_i,
  input  logic       event_ready_i,
  input  logic [1:0] event_kind_i,
  input  logic [7:0] payload_byte_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef enum logic [2:0] {
    PhSize, PhSizeLf, PhData, PhTrail1, PhTrail2, PhLastCr, PhLastLf, PhHalt
  } phase_e;

  typedef struct packed {
    hbd_pkg::event_kind_e kind;
    logic [7:0]           data;
  } event_t;

  localparam int PrintCap = 100;

  // Mirror of the framing state and the suppress register.
  phase_e              phase;
  logic [SizeBits-1:0] size_acc;
  logic [SizeBits-1:0] bytes_left;
  logic [3:0]          digits;
  logic                suppress;

  event_t events_due_q[$];
  int     mismatches;
  int     events_seen;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    // Printing stops after a while so a badly broken block cannot flood the log.
    if (mismatches < PrintCap) begin
      $display("mismatch at event %0d: %s got %0d expected %0d",
               events_seen, what, got_v, want_v);
    end
    mismatches++;
  endtask

  // Advances the mirrored framing state by one body byte; returns 1 when an event is due.
  function automatic logic decode_byte(input logic [7:0] b, output event_t ev);
    logic       raise_err;
    logic       is_hex;
    logic [3:0] nib;
    logic       fires;
    raise_err = 1'b0;
    fires     = 1'b0;
    is_hex    = 1'b1;
    nib       = '0;
    ev        = '{kind: hbd_pkg::EvPayload, data: 8'h00};
    if (b >= 8'h30 && b <= 8'h39) begin
      nib = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      nib = b[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
    case (phase)
      PhSize: begin
        if (b == hbd_pkg::ChCr) begin
          if (digits == '0) raise_err = 1'b1;
          else phase = PhSizeLf;
        end else if (!is_hex || digits >= MaxSizeLine || size_acc[SizeBits-1 -: 4] != '0) begin
          raise_err = 1'b1;
        end else begin
          size_acc = {size_acc[SizeBits-5:0], nib};
          digits   = digits + 4'd1;
        end
      end
      PhSizeLf: begin
        if (b != hbd_pkg::ChLf) begin
          raise_err = 1'b1;
        end else if (size_acc == '0) begin
          phase = PhLastCr;
        end else begin
          bytes_left = size_acc;
          phase      = PhData;
        end
      end
      PhData: begin
        if (bytes_left != '0) bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) phase = PhTrail1;
        if (!suppress) begin
          ev.kind = hbd_pkg::EvPayload;
          ev.data = b;
          fires   = 1'b1;
        end
      end
      PhTrail1: phase = PhTrail2;
      PhTrail2: begin
        phase    = PhSize;
        size_acc = '0;
        digits   = '0;
      end
      PhLastCr: begin
        if (b != hbd_pkg::ChCr) raise_err = 1'b1;
        else phase = PhLastLf;
      end
      PhLastLf: begin
        if (b != hbd_pkg::ChLf) begin
          raise_err = 1'b1;
        end else begin
          phase      = PhSize;
          size_acc   = '0;
          digits     = '0;
          bytes_left = '0;
          ev.kind    = hbd_pkg::EvDone;
          fires      = 1'b1;
        end
      end
      default: ;
    endcase
    if (raise_err) begin
      phase   = PhHalt;
      ev.kind = hbd_pkg::EvError;
      ev.data = 8'h00;
      fires   = 1'b1;
    end
    return fires;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : score
    event_t want;
    event_t ev;
    if (!rst_ni) begin
      phase        = PhSize;
      size_acc     = '0;
      bytes_left   = '0;
      digits       = '0;
      suppress     = 1'b0;
      mismatches   = 0;
      events_seen  = 0;
      events_due_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (event_valid_i && event_ready_i) begin
        if (events_due_q.size() == 0) begin
          report_mismatch("event with none expected, kind", event_kind_i, -1);
        end else begin
          want = events_due_q.pop_front();
          if (event_kind_i != want.kind) report_mismatch("event_kind", event_kind_i, want.kind);
          if (payload_byte_i != want.data) begin
            report_mismatch("payload_byte", payload_byte_i, want.data);
          end
        end
        events_seen++;
      end
      if (body_valid_i && body_ready_i && decode_byte(body_byte_i, ev)) begin
        events_due_q.push_back(ev);
      end
      // The register takes its new value at this edge, after the byte accepted here.
      if (cfg_we_i) suppress = cfg_wdata_i;
      pending_o    <= events_due_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> tb/sv/tb_http_chunked_body_decoder.sv
// Testbench top: clock, reset, body stimulus, event sink, watchdog and verdict.
module tb_http_chunked_body_decoder;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;
  localparam int LongHold      = 64;
  localparam int NumPhases     = 5;

  localparam int   IdleTab[NumPhases]     = '{0, 52, 0, 8, 0};
  localparam int   StallTab[NumPhases]    = '{0, 0, 52, 8, 0};
  localparam logic SuppressTab[NumPhases] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam int   BudgetTab[NumPhases]   = '{190, 150, 190, 150, 170};

  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerA = 8'h61;

  typedef enum logic [2:0] {
    FaultBadDigit, FaultEmptyLine, FaultLongLine, FaultOverflow, FaultNoLf, FaultBadEnd
  } fault_e;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       body_valid_i  = 1'b0;
  logic [7:0] body_byte_i   = 8'h00;
  logic       event_ready_i = 1'b0;
  logic       body_ready_o;
  logic       event_valid_o;
  logic [1:0] event_kind_o;
  logic [7:0] payload_byte_o;

  int fail_count;
  int pending_events;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_token      = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  logic [7:0] stream_q[$];

  always #2 clk_i = ~clk_i;

  http_chunked_body_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .body_valid_i   (body_valid_i),
    .body_ready_o   (body_ready_o),
    .body_byte_i    (body_byte_i),
    .event_valid_o  (event_valid_o),
    .event_ready_i  (event_ready_i),
    .event_kind_o   (event_kind_o),
    .payload_byte_o (payload_byte_o)
  );

  hbd_event_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .body_valid_i   (body_valid_i),
    .body_ready_i   (body_ready_o),
    .body_byte_i    (body_byte_i),
    .event_valid_i  (event_valid_o),
    .event_ready_i  (event_ready_i),
    .event_kind_i   (event_kind_o),
    .payload_byte_i (payload_byte_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_events)
  );

  // Event sink: random stalls, plus a long hold-off whenever the stimulus bumps the token.
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_left     <= LongHold;
      event_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      event_ready_i <= 1'b0;
    end else begin
      event_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((body_valid_i && body_ready_o) || (event_valid_o && event_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_http_chunked_body_decoder failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic is_hex_char(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return ChZero + nib;
    return ($urandom_range(1) ? ChUpperA : ChLowerA) + nib - 8'd10;
  endfunction

  function automatic void put_hex(input logic [35:0] value, input int ndig);
    for (int i = ndig - 1; i >= 0; i--) stream_q.push_back(hex_char(value[4*i +: 4]));
  endfunction

  function automatic void put_crlf();
    stream_q.push_back(hbd_pkg::ChCr);
    stream_q.push_back(hbd_pkg::ChLf);
  endfunction

  // Size line with the fewest digits, or now and then padded with leading zeros.
  function automatic void put_size_line(input int unsigned size);
    int need;
    int ndig;
    need = 1;
    while ((size >> (4 * need)) != 0) need++;
    ndig = need;
    if ($urandom_range(3) == 0) ndig += $urandom_range(hbd_pkg::MaxSizeLineDef - need);
    put_hex(36'(size), ndig);
    put_crlf();
  endfunction

  function automatic void put_chunk(input int unsigned size);
    put_size_line(size);
    repeat (size) stream_q.push_back(8'($urandom_range(255)));
    // The two bytes after the data are not checked, so they are sometimes junk.
    if ($urandom_range(3) != 0) begin
      put_crlf();
    end else begin
      stream_q.push_back(8'($urandom_range(255)));
      stream_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void put_body();
    int unsigned size;
    repeat ($urandom_range(4)) begin
      size = ($urandom_range(19) == 0) ? $urandom_range(300, 40) : $urandom_range(12, 1);
      put_chunk(size);
    end
    put_size_line(0);
    put_crlf();
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid, input logic no_hex);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == avoid || (no_hex && is_hex_char(b)));
    return b;
  endfunction

  // A body that breaks its framing; the block halts on it for the rest of the run.
  function automatic void put_broken_body(input fault_e fault);
    case (fault)
      FaultBadDigit: begin
        repeat ($urandom_range(3)) stream_q.push_back(hex_char(4'($urandom_range(15))));
        stream_q.push_back(byte_other_than(hbd_pkg::ChCr, 1'b1));
      end
      FaultEmptyLine: stream_q.push_back(hbd_pkg::ChCr);
      FaultLongLine: begin
        put_hex(36'd0, hbd_pkg::MaxSizeLineDef);
        stream_q.push_back(hex_char(4'($urandom_range(15))));
      end
      FaultOverflow: begin
        stream_q.push_back(hex_char(4'($urandom_range(15, 1))));
        repeat (8) stream_q.push_back(hex_char(4'($urandom_range(15))));
      end
      FaultNoLf: begin
        put_hex(36'($urandom_range(15, 1)), 1);
        stream_q.push_back(hbd_pkg::ChCr);
        stream_q.push_back(byte_other_than(hbd_pkg::ChLf, 1'b0));
      end
      default: begin
        put_size_line(0);
        if ($urandom_range(1)) begin
          stream_q.push_back(byte_other_than(hbd_pkg::ChCr, 1'b0));
        end else begin
          stream_q.push_back(hbd_pkg::ChCr);
          stream_q.push_back(byte_other_than(hbd_pkg::ChLf, 1'b0));
        end
      end
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] b);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      body_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    body_valid_i <= 1'b1;
    body_byte_i  <= b;
    do @(posedge clk_i); while (!body_ready_o);
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) send_beat(stream_q.pop_front());
  endtask

  task automatic wait_drained();
    body_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_events != 0);
  endtask

  // Suppressed data beats leave nothing to wait for, so an extra drain wait lets them retire.
  task automatic write_suppress(input logic value);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    int sent;
    int bodies;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_suppress(1'b0);

    // Short chunks, a nine-digit size line, extreme data bytes, then the last chunk.
    put_hex(36'd1, 1);
    put_crlf();
    stream_q.push_back(8'h00);
    put_crlf();
    put_hex(36'd2, hbd_pkg::MaxSizeLineDef);
    put_crlf();
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h80);
    put_crlf();
    put_hex(36'd0, 1);
    put_crlf();
    put_crlf();
    send_stream();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_suppress(SuppressTab[ph]);
      sender_idle_pct = IdleTab[ph];
      stall_pct      <= StallTab[ph];
      // Hold the sink off while beats keep coming so the block backs up to its input.
      if (ph == 2) hold_token <= hold_token + 1;
      sent   = 0;
      bodies = 0;
      while (sent < BudgetTab[ph]) begin
        put_body();
        sent += stream_q.size();
        send_stream();
        bodies++;
        if ((ph == 0 && bodies == 1) || $urandom_range(11) == 0) wait_drained();
      end
    end

    // The halt after an error is sticky, so only one fault kind fits in a run.
    put_broken_body(fault_e'($urandom_range(5)));
    repeat (16) stream_q.push_back(8'($urandom_range(255)));
    send_stream();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_http_chunked_body_decoder passed");
    end else begin
      $display("tb_http_chunked_body_decoder failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/hbd_pkg.sv
sv/hbd_front.sv
sv/hbd_queue.sv
sv/hbd_back.sv
sv/http_chunked_body_decoder.sv
tb/sv/hbd_event_checker.sv
tb/sv/tb_http_chunked_body_decoder.sv
